// File: rtl/bmw_pkg.sv
package bmw_pkg;

    localparam int WINDOW_DEF    = 3;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int TDATA_W    = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLEVEL_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;

    // per-result flags handed from front to back
    typedef struct packed {
        logic center;
        logic interior;
        logic last;
    } t_flags;

endpackage

// File: rtl/bmw_ram.sv
module bmw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bmw_front.sv
module bmw_front
    import bmw_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic                               i_pixel,
    input  logic                               i_padding,
    input  logic [IMG_W_W-1:0]                 i_width,
    input  logic [IMG_H_W-1:0]                 i_height,
    input  logic [QLEVEL_W-1:0]                i_q_level,
    output logic                               o_push,
    output logic [2*((WINDOW-1)/2):0]          o_col,
    output t_flags                             o_flags
);

    localparam int M  = (WINDOW - 1) / 2;
    localparam int NR = 2 * M + 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = WW + 1;
    localparam int EW = (WW > IMG_W_W) ? WW : IMG_W_W;
    localparam int HW = IMG_H_W + 1;
    localparam int SW = $clog2(WINDOW);
    localparam int PW = $clog2(M * MAX_WIDTH + M + 2);

    logic [CW-1:0]      r_in_col,  n_in_col;
    logic [IMG_H_W-1:0] r_in_row,  n_in_row;
    logic [CW-1:0]      r_out_col, n_out_col;
    logic [IMG_H_W-1:0] r_out_row, n_out_row;
    logic [SW-1:0]      r_wslot,   n_wslot;
    logic [SW-1:0]      r_rslot,   n_rslot;
    logic [PW-1:0]      r_pending, n_pending;

    // stage B: line store read data comes back
    logic               r_b_valid;
    logic               r_b_interior;
    logic               r_b_last;
    logic [SW-1:0]      r_sel [NR];
    logic [SW-1:0]      r_csel;
    logic               r_byp_w;
    logic               r_byp_c;
    logic [SW-1:0]      r_bslot;
    logic               r_bpix;

    logic [EW-1:0]      w_ext;
    logic [WW-1:0]      w_cur;
    logic [IMG_H_W-1:0] h_cur;
    logic [PW-1:0]      w_delay;
    logic               w_acc;
    logic               w_pix_acc;
    logic               w_pad_acc;
    logic               w_emit;
    logic               w_in_wrap;
    logic               w_out_wrap;
    logic [SW-1:0]      w_rslot_inc;
    logic [SW-1:0]      w_wslot_inc;
    logic [XW-1:0]      w_cw;
    logic [CW-1:0]      w_win_addr;
    logic [SW-1:0]      w_base;
    logic [SW-1:0]      w_sel [NR];
    logic               w_interior;
    logic               w_last;
    logic [WINDOW-1:0]  w_we;
    logic [WINDOW-1:0]  w_ram_win;
    logic [WINDOW-1:0]  w_ram_ctr;
    logic [WINDOW-1:0]  w_win_vec;
    logic [WINDOW-1:0]  w_ctr_vec;

    always_comb begin
        w_ext = EW'(i_width);
        if (i_width == '0) begin
            w_cur = WW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_cur = WW'(MAX_WIDTH);
        end else begin
            w_cur = w_ext[WW-1:0];
        end
        h_cur = (i_height == '0) ? IMG_H_W'(1) : i_height;
    end

    assign w_delay = PW'(M) * PW'(w_cur) + PW'(M);

    assign o_s_tready = (QLEVEL_W'(i_q_level) + QLEVEL_W'(r_b_valid)) <
                        QLEVEL_W'(QUEUE_DEPTH);
    assign w_acc     = i_s_tvalid && o_s_tready;
    assign w_pix_acc = w_acc && !i_padding;
    assign w_pad_acc = w_acc && i_padding;

    always_comb begin
        if (w_pix_acc) begin
            w_emit = (r_pending + PW'(1)) > w_delay;
        end else begin
            w_emit = w_pad_acc && (r_in_col == '0) && (r_in_row == '0) &&
                     (r_pending != '0);
        end
    end

    assign w_in_wrap   = (XW'(r_in_col) + XW'(1)) >= XW'(w_cur);
    assign w_out_wrap  = (XW'(r_out_col) + XW'(1)) >= XW'(w_cur);
    assign w_rslot_inc = (r_rslot == SW'(WINDOW - 1)) ? '0 : r_rslot + SW'(1);
    assign w_wslot_inc = (r_wslot == SW'(WINDOW - 1)) ? '0 : r_wslot + SW'(1);

    assign w_interior = (XW'(r_out_col) >= XW'(M)) &&
                        ((XW'(r_out_col) + XW'(M)) < XW'(w_cur)) &&
                        (HW'(r_out_row) >= HW'(M)) &&
                        ((HW'(r_out_row) + HW'(M)) < HW'(h_cur));
    assign w_last     = w_out_wrap && ((HW'(r_out_row) + HW'(1)) >= HW'(h_cur));

    // column that enters the window: M right of the output pixel, wrapping
    // onto the next row so the left edge is preloaded at row end
    always_comb begin
        int t;
        w_cw   = XW'(r_out_col) + XW'(M);
        w_base = r_rslot;
        if (w_cw >= XW'(w_cur)) begin
            w_cw   = w_cw - XW'(w_cur);
            w_base = w_rslot_inc;
        end
        w_win_addr = w_cw[CW-1:0];
        for (int dr = 0; dr < NR; dr++) begin
            t = int'(w_base) + WINDOW - M + dr;
            if (t >= WINDOW) t = t - WINDOW;
            if (t >= WINDOW) t = t - WINDOW;
            w_sel[dr] = SW'(t);
        end
        for (int s = 0; s < WINDOW; s++) begin
            w_we[s] = w_pix_acc && (r_wslot == SW'(s));
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_wslot   = r_wslot;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_rslot   = r_rslot;
        n_pending = r_pending;
        if (w_pix_acc) begin
            if (w_in_wrap) begin
                n_in_col = '0;
                n_wslot  = w_wslot_inc;
                n_in_row = ((HW'(r_in_row) + HW'(1)) >= HW'(h_cur)) ? '0 :
                           r_in_row + IMG_H_W'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            n_pending = r_pending + PW'(1);
        end
        if (w_emit) begin
            if (w_out_wrap) begin
                n_out_col = '0;
                n_rslot   = w_rslot_inc;
                n_out_row = ((HW'(r_out_row) + HW'(1)) >= HW'(h_cur)) ? '0 :
                            r_out_row + IMG_H_W'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
            n_pending = n_pending - PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_pending <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_wslot   <= n_wslot;
            r_rslot   <= n_rslot;
            r_pending <= n_pending;
            r_b_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_interior <= w_interior;
        r_b_last     <= w_last;
        r_sel        <= w_sel;
        r_csel       <= r_rslot;
        r_byp_w      <= w_pix_acc && (w_win_addr == r_in_col);
        r_byp_c      <= w_pix_acc && (r_out_col == r_in_col);
        r_bslot      <= r_wslot;
        r_bpix       <= i_pixel;
    end

    // line store: one slot per window row, two read copies per slot
    for (genvar s = 0; s < WINDOW; s++) begin : g_slot
        bmw_ram #(
            .WIDTH (1),
            .DEPTH (MAX_WIDTH)
        ) u_win_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[s]),
            .i_waddr (r_in_col),
            .i_wdata (i_pixel),
            .i_raddr (w_win_addr),
            .o_rdata (w_ram_win[s])
        );
        bmw_ram #(
            .WIDTH (1),
            .DEPTH (MAX_WIDTH)
        ) u_ctr_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[s]),
            .i_waddr (r_in_col),
            .i_wdata (i_pixel),
            .i_raddr (r_out_col),
            .o_rdata (w_ram_ctr[s])
        );
    end

    // pixel written in the same cycle as the read wins over the old word
    always_comb begin
        for (int s = 0; s < WINDOW; s++) begin
            w_win_vec[s] = (r_byp_w && (r_bslot == SW'(s))) ? r_bpix : w_ram_win[s];
            w_ctr_vec[s] = (r_byp_c && (r_bslot == SW'(s))) ? r_bpix : w_ram_ctr[s];
        end
        for (int dr = 0; dr < NR; dr++) begin
            o_col[dr] = w_win_vec[r_sel[dr]];
        end
        o_flags.center   = w_ctr_vec[r_csel];
        o_flags.interior = r_b_interior;
        o_flags.last     = r_b_last;
    end

    assign o_push = r_b_valid;

`ifndef ASSERT_OFF
    a_pad_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pad_acc && !w_emit |=> $stable(r_pending))
        else $error("ignored padding item changed the pending count");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pix_acc && !w_emit |=> r_pending == $past(r_pending) + PW'(1))
        else $error("pixel without result did not raise the pending count");

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_in_col) < XW'(MAX_WIDTH))
        else $error("input column left the line store");
`endif

endmodule

// File: rtl/bmw_queue.sv
module bmw_queue
    import bmw_pkg::*;
#(
    parameter int NR = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [NR-1:0]       i_col,
    input  t_flags              i_flags,
    input  logic                i_pop,
    output logic                o_valid,
    output logic [NR-1:0]       o_col,
    output t_flags              o_flags,
    output logic [QLEVEL_W-1:0] o_level
);

    logic [NR-1:0]       r_col [QUEUE_DEPTH];
    t_flags              r_flg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QLEVEL_W-1:0] r_level;
    logic                w_pop;

    assign w_pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_level <= r_level + QLEVEL_W'(i_push) - QLEVEL_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_col[r_wptr] <= i_col;
            r_flg[r_wptr] <= i_flags;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_col   = r_col[r_rptr];
    assign o_flags = r_flg[r_rptr];
    assign o_level = r_level;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_level < QLEVEL_W'(QUEUE_DEPTH))
        else $error("item pushed into a full queue");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= QLEVEL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");
`endif

endmodule

// File: rtl/bmw_back.sv
module bmw_back
    import bmw_pkg::*;
#(
    parameter int NR = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mode,
    input  logic          i_valid,
    input  logic [NR-1:0] i_col,
    input  t_flags        i_flags,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic          o_pixel,
    output logic          o_last
);

    logic [NR*NR-1:0] r_win;
    logic [NR*NR-1:0] n_win;
    logic             r_out_valid;
    logic             r_out_pixel;
    logic             r_out_last;
    logic             w_result;

    assign o_pop = i_valid && (!r_out_valid || i_m_tready);

    // newest column in the low bits; the window order does not matter
    // for a plain AND / OR
    assign n_win = {r_win[NR*NR-NR-1:0], i_col};

    always_comb begin
        if (!i_flags.interior) begin
            w_result = i_flags.center;
        end else if (i_mode == MODE_DILATE) begin
            w_result = |n_win;
        end else begin
            w_result = &n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_win       <= n_win;
            r_out_pixel <= w_result;
            r_out_last  <= i_flags.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_pixel    = r_out_pixel;
    assign o_last     = r_out_last;

`ifndef ASSERT_OFF
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped item did not reach the output register");
`endif

endmodule

// File: rtl/binary_morphology_window.sv
// Channel  Direction  Handshake               Payload
// s        in         i_s_tvalid/o_s_tready   tdata[0] pixel_in, tuser padding
// m        out        o_m_tvalid/i_m_tready   tdata[0] pixel_out, tlast frame_last
// cfg      in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the queue has room. A result passes the
// line store read, the queue and the output stage before it leaves the output
// register. Results trail the pixel stream by M*width+M items, M = (WINDOW-1)/2.
// The line store has no clearing pass; entries are undefined until written.
// The input stalls only when the four-entry queue, with the item in the line
// store read counted, is full, i.e. when the output side holds tready low.
module binary_morphology_window
    import bmw_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TDATA_W-1:0]    i_s_tdata,    // [0] pixel_in
    input  logic                  i_s_tuser,    // [0] padding
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_W-1:0]    o_m_tdata,    // [0] pixel_out
    output logic                  o_m_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NR = 2 * ((WINDOW - 1) / 2) + 1;

    logic                r_mode;
    logic [IMG_W_W-1:0]  r_width;
    logic [IMG_H_W-1:0]  r_height;

    logic                w_push;
    logic [NR-1:0]       w_f_col;
    t_flags              w_f_flags;
    logic                w_q_valid;
    logic [NR-1:0]       w_q_col;
    t_flags              w_q_flags;
    logic [QLEVEL_W-1:0] w_q_level;
    logic                w_pop;
    logic                w_pixel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ERODE;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[IMG_H_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bmw_front #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_pixel    (i_s_tdata[0]),
        .i_padding  (i_s_tuser),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_q_level  (w_q_level),
        .o_push     (w_push),
        .o_col      (w_f_col),
        .o_flags    (w_f_flags)
    );

    bmw_queue #(
        .NR (NR)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_col   (w_f_col),
        .i_flags (w_f_flags),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_col   (w_q_col),
        .o_flags (w_q_flags),
        .o_level (w_q_level)
    );

    bmw_back #(
        .NR (NR)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_valid    (w_q_valid),
        .i_col      (w_q_col),
        .i_flags    (w_q_flags),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_pixel    (w_pixel),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {{(TDATA_W-1){1'b0}}, w_pixel};

endmodule
